/* rtl/qau_pkg.sv */
// Shared types, widths and latency figures for the quaternion arithmetic unit.
// Depends on nothing; every rtl file imports it.
package qau_pkg;

   // Fixed point format and derived widths.
   localparam int FRAC_BITS = 16;
   localparam int SUM_W     = 67;
   localparam int NUM_W     = 65;
   localparam int Q_W       = FRAC_BITS + 2;

   // Pipeline latencies in clock cycles.
   localparam int DIV_LAT  = FRAC_BITS + 2;
   localparam int MAT_LAT  = DIV_LAT + 3;
   localparam int QUAT_LAT = 4;
   localparam int QDELAY   = MAT_LAT - QUAT_LAT;

   typedef logic signed [31:0] fix_type;
   typedef fix_type [3:0] quad_type;

   localparam fix_type FIX_MAX = 32'sh7fffffff;
   localparam fix_type FIX_MIN = 32'sh80000000;
   localparam fix_type FIX_ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

   // Operation codes.
   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_ROT = 2'd1,
      OP_MAT = 2'd2
   } op_type;

   // Quaternion path result.
   typedef struct packed {
      quad_type val;
      logic     sat;
   } quat_res_type;

endpackage

/* rtl/quaternion_arithmetic_unit.sv */
// Quaternion arithmetic unit, fully pipelined: one transaction per cycle.
// Every op has the same latency, set by the restoring divider lanes of the matrix
// path (Q16.16 data), one bit per stage.
// busy is always low; the receiver cannot stall, each result shows one cycle.
// Synchronous active high reset clears the valid pipeline; no data is reset.
module quaternion_arithmetic_unit import qau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  fix_type     req_a_w,
   input  fix_type     req_a_x,
   input  fix_type     req_a_y,
   input  fix_type     req_a_z,
   input  fix_type     req_b_w,
   input  fix_type     req_b_x,
   input  fix_type     req_b_y,
   input  fix_type     req_b_z,
   output logic        rsp_valid,
   output fix_type     rsp_res_0,
   output fix_type     rsp_res_1,
   output fix_type     rsp_res_2,
   output fix_type     rsp_res_3,
   output fix_type     rsp_res_4,
   output fix_type     rsp_res_5,
   output fix_type     rsp_res_6,
   output fix_type     rsp_res_7,
   output fix_type     rsp_res_8,
   output logic        rsp_zero_norm,
   output logic        rsp_saturated
);

   logic           accept;
   logic           vld_ff [MAT_LAT];
   op_type         op_ff  [MAT_LAT];
   fix_type        bw;
   quad_type       b1_a [4], b1_b [4];
   logic [3:0]     b1_sub [4];
   quad_type       b1_res;
   logic [3:0]     b1_sat;
   quad_type       ad_ff [2];
   quad_type       b1d_ff [2];
   logic           b1sd_ff [2];
   quad_type       b2_a [3], b2_b [3];
   fix_type        t0, t1, t2, t3, aw, ax, ay, az;
   fix_type        b2_res [3];
   logic [2:0]     b2_sat;
   quat_res_type   qr_in;
   quat_res_type   qd_ff [QDELAY];
   fix_type [8:0]  mat;
   logic           mat_zn;
   fix_type [8:0]  res_in, res_ff;
   logic           zn_in, zn_ff, sat_in, sat_ff, rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Valid and op code pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < MAT_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[MAT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      op_ff[0] <= op_type'(req_op);
      for (int i = 1; i < MAT_LAT; i++) begin
         op_ff[i] <= op_ff[i-1];
      end
   end

   // First product bank: Hamilton product, or a*(0,b) with b_w forced to zero.
   always_comb begin
      bw = (op_type'(req_op) == OP_ROT) ? '0 : req_b_w;
      b1_a[0] = {req_a_z, req_a_y, req_a_x, req_a_w};
      b1_b[0] = {req_b_z, req_b_y, req_b_x, bw};
      b1_sub[0] = 4'b1110;
      b1_a[1] = {req_a_z, req_a_y, bw, req_a_w};
      b1_b[1] = {req_b_y, req_b_z, req_a_x, req_b_x};
      b1_sub[1] = 4'b1000;
      b1_a[2] = {req_a_x, req_a_z, bw, req_a_w};
      b1_b[2] = {req_b_z, req_b_x, req_a_y, req_b_y};
      b1_sub[2] = 4'b1000;
      b1_a[3] = {req_a_y, req_a_x, bw, req_a_w};
      b1_b[3] = {req_b_x, req_b_y, req_a_z, req_b_z};
      b1_sub[3] = 4'b1000;
   end

   for (genvar k = 0; k < 4; k++) begin : g_bank1
      qau_mac_lane u_lane (
         .clock (clock),
         .mul_a (b1_a[k]),
         .mul_b (b1_b[k]),
         .sub   (b1_sub[k]),
         .res   (b1_res[k]),
         .sat   (b1_sat[k])
      );
   end

   // Align quaternion a and the first bank results with the second bank.
   always_ff @(posedge clock) begin
      ad_ff[0]   <= {req_a_z, req_a_y, req_a_x, req_a_w};
      ad_ff[1]   <= ad_ff[0];
      b1d_ff[0]  <= b1_res;
      b1d_ff[1]  <= b1d_ff[0];
      b1sd_ff[0] <= |b1_sat;
      b1sd_ff[1] <= b1sd_ff[0];
   end

   // Second product bank: t * conj(a).
   always_comb begin
      t0 = b1_res[0];
      t1 = b1_res[1];
      t2 = b1_res[2];
      t3 = b1_res[3];
      aw = ad_ff[1][0];
      ax = ad_ff[1][1];
      ay = ad_ff[1][2];
      az = ad_ff[1][3];
      b2_a[0] = {t2, t3, t0, aw};
      b2_b[0] = {az, ay, ax, t1};
      b2_a[1] = {t3, t1, t0, aw};
      b2_b[1] = {ax, az, ay, t2};
      b2_a[2] = {t1, t2, t0, aw};
      b2_b[2] = {ay, ax, az, t3};
   end

   for (genvar k = 0; k < 3; k++) begin : g_bank2
      qau_mac_lane u_lane (
         .clock (clock),
         .mul_a (b2_a[k]),
         .mul_b (b2_b[k]),
         .sub   (4'b1010),
         .res   (b2_res[k]),
         .sat   (b2_sat[k])
      );
   end

   // Pick the quaternion path result for this op.
   always_comb begin
      case (op_ff[QUAT_LAT-1])
         OP_MUL: begin
            qr_in.val = b1d_ff[1];
            qr_in.sat = b1sd_ff[1];
         end
         OP_ROT: begin
            qr_in.val = {32'sd0, b2_res[2], b2_res[1], b2_res[0]};
            qr_in.sat = b1sd_ff[1] || (|b2_sat);
         end
         default: begin
            qr_in.val = '0;
            qr_in.sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      qd_ff[0] <= qr_in;
      for (int i = 1; i < QDELAY; i++) begin
         qd_ff[i] <= qd_ff[i-1];
      end
   end

   // Matrix path.
   qau_matrix u_matrix (
      .clock     (clock),
      .a_w       (req_a_w),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .a_z       (req_a_z),
      .mat       (mat),
      .zero_norm (mat_zn)
   );

   // Merge stage.
   always_comb begin
      res_in = '0;
      zn_in  = 1'b0;
      sat_in = 1'b0;
      case (op_ff[MAT_LAT-1])
         OP_MUL, OP_ROT: begin
            res_in[3:0] = qd_ff[QDELAY-1].val;
            sat_in      = qd_ff[QDELAY-1].sat;
         end
         OP_MAT: begin
            res_in = mat;
            zn_in  = mat_zn;
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      zn_ff  <= zn_in;
      sat_ff <= sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_0     = res_ff[0];
   assign rsp_res_1     = res_ff[1];
   assign rsp_res_2     = res_ff[2];
   assign rsp_res_3     = res_ff[3];
   assign rsp_res_4     = res_ff[4];
   assign rsp_res_5     = res_ff[5];
   assign rsp_res_6     = res_ff[6];
   assign rsp_res_7     = res_ff[7];
   assign rsp_res_8     = res_ff[8];
   assign rsp_zero_norm = zn_ff;
   assign rsp_saturated = sat_ff;

endmodule

/* rtl/qau_mac_lane.sv */
// One lane: a signed sum of four 32x32 products, rounded half up and saturated.
// Two register stages (products, then rounded sum). Uses qau_pkg.
module qau_mac_lane import qau_pkg::*; (
   input  logic     clock,
   input  quad_type mul_a,
   input  quad_type mul_b,
   input  logic [3:0] sub,
   output fix_type  res,
   output logic     sat
);

   logic signed [63:0]      prod_ff [4];
   logic [3:0]              sub_ff;
   logic signed [SUM_W-1:0] acc;
   logic signed [SUM_W-1:0] rnd;
   logic                    ovf;
   fix_type                 res_ff, res_in;
   logic                    sat_ff;

   // Product stage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         prod_ff[i] <= $signed(mul_a[i]) * $signed(mul_b[i]);
      end
      sub_ff <= sub;
   end

   // Accumulate, round half up and clip to the 32 bit range.
   always_comb begin
      acc = ROUND_HALF;
      for (int i = 0; i < 4; i++) begin
         if (sub_ff[i]) begin
            acc = acc - SUM_W'(prod_ff[i]);
         end else begin
            acc = acc + SUM_W'(prod_ff[i]);
         end
      end
      rnd = acc >>> FRAC_BITS;
      ovf = !((&rnd[SUM_W-1:31]) || !(|rnd[SUM_W-1:31]));
      if (ovf) begin
         res_in = rnd[SUM_W-1] ? FIX_MIN : FIX_MAX;
      end else begin
         res_in = rnd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      sat_ff <= ovf;
   end

   assign res = res_ff;
   assign sat = sat_ff;

endmodule

/* rtl/qau_div_lane.sv */
// Restoring divider lane: rounds sign * num * 2^FRAC_BITS / den, num <= den.
// One quotient bit per stage, DIV_LAT register stages. Uses qau_pkg.
module qau_div_lane import qau_pkg::*; (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   input  logic             neg,
   output fix_type          quot
);

   logic [NUM_W-1:0] rem_ff [FRAC_BITS+1];
   logic [NUM_W-1:0] den_ff [FRAC_BITS+1];
   logic [Q_W-1:0]   quo_ff [FRAC_BITS+1];
   logic             neg_ff [FRAC_BITS+1];
   logic [NUM_W-1:0] rem_in [FRAC_BITS+1];
   logic [Q_W-1:0]   quo_in [FRAC_BITS+1];
   logic [NUM_W:0]   shl    [FRAC_BITS+1];
   logic [NUM_W:0]   dif    [FRAC_BITS+1];
   logic             ge;
   logic [NUM_W:0]   shf;
   logic             rnd;
   logic [Q_W-1:0]   qpos, qneg;
   fix_type          quot_ff, quot_in;

   // Integer bit, then one fraction bit per stage.
   always_comb begin
      ge        = num >= den;
      rem_in[0] = ge ? num - den : num;
      quo_in[0] = Q_W'(ge);
      shl[0]    = '0;
      dif[0]    = '0;
      for (int i = 1; i <= FRAC_BITS; i++) begin
         shl[i] = {rem_ff[i-1], 1'b0};
         dif[i] = shl[i] - {1'b0, den_ff[i-1]};
         if (shl[i] >= {1'b0, den_ff[i-1]}) begin
            rem_in[i] = dif[i][NUM_W-1:0];
            quo_in[i] = {quo_ff[i-1][Q_W-2:0], 1'b1};
         end else begin
            rem_in[i] = shl[i][NUM_W-1:0];
            quo_in[i] = {quo_ff[i-1][Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff[0] <= den;
      neg_ff[0] <= neg;
      for (int i = 0; i <= FRAC_BITS; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
      end
      for (int i = 1; i <= FRAC_BITS; i++) begin
         den_ff[i] <= den_ff[i-1];
         neg_ff[i] <= neg_ff[i-1];
      end
   end

   // Round half away from zero and apply the sign.
   always_comb begin
      shf  = {rem_ff[FRAC_BITS], 1'b0};
      rnd  = shf >= {1'b0, den_ff[FRAC_BITS]};
      qpos = quo_ff[FRAC_BITS] + Q_W'(rnd);
      qneg = ~quo_ff[FRAC_BITS] + Q_W'(!rnd);
      quot_in = neg_ff[FRAC_BITS] ? 32'($signed(qneg)) : 32'(qpos);
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

/* rtl/qau_matrix.sv */
// Rotation matrix path: squares and cross products, numerators, norm, and
// nine divider lanes. Uses qau_pkg and qau_div_lane.
module qau_matrix import qau_pkg::*; (
   input  logic           clock,
   input  fix_type        a_w,
   input  fix_type        a_x,
   input  fix_type        a_y,
   input  fix_type        a_z,
   output fix_type [8:0]  mat,
   output logic           zero_norm
);

   logic [63:0]        w2_ff, x2_ff, y2_ff, z2_ff;
   logic signed [63:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic [63:0]        s_wx_ff, s_yz_ff, s_wy_ff, s_xz_ff, s_wz_ff, s_xy_ff;
   logic signed [64:0] off_ff [6];
   logic [NUM_W-1:0]   num_ff [9];
   logic               neg_ff [9];
   logic [NUM_W-1:0]   den_ff;
   logic               zn_ff;
   logic               zd_ff [DIV_LAT];
   logic [64:0]        dpos [3], dneg [3];
   logic signed [64:0] offn [6];
   fix_type            quo [9];

   // Squares and cross products, all formed at full 64 bit width.
   always_ff @(posedge clock) begin
      w2_ff <= 64'(a_w) * 64'(a_w);
      x2_ff <= 64'(a_x) * 64'(a_x);
      y2_ff <= 64'(a_y) * 64'(a_y);
      z2_ff <= 64'(a_z) * 64'(a_z);
      xy_ff <= 64'(a_x) * 64'(a_y);
      xz_ff <= 64'(a_x) * 64'(a_z);
      yz_ff <= 64'(a_y) * 64'(a_z);
      wx_ff <= 64'(a_w) * 64'(a_x);
      wy_ff <= 64'(a_w) * 64'(a_y);
      wz_ff <= 64'(a_w) * 64'(a_z);
   end

   // Pair sums and signed off-diagonal numerators.
   always_ff @(posedge clock) begin
      s_wx_ff   <= w2_ff + x2_ff;
      s_yz_ff   <= y2_ff + z2_ff;
      s_wy_ff   <= w2_ff + y2_ff;
      s_xz_ff   <= x2_ff + z2_ff;
      s_wz_ff   <= w2_ff + z2_ff;
      s_xy_ff   <= x2_ff + y2_ff;
      off_ff[0] <= 65'(xy_ff) - 65'(wz_ff);
      off_ff[1] <= 65'(xz_ff) + 65'(wy_ff);
      off_ff[2] <= 65'(xy_ff) + 65'(wz_ff);
      off_ff[3] <= 65'(yz_ff) - 65'(wx_ff);
      off_ff[4] <= 65'(xz_ff) - 65'(wy_ff);
      off_ff[5] <= 65'(yz_ff) + 65'(wx_ff);
   end

   // Diagonal differences both ways, off-diagonal negations.
   always_comb begin
      dpos[0] = {1'b0, s_wx_ff} - {1'b0, s_yz_ff};
      dneg[0] = {1'b0, s_yz_ff} - {1'b0, s_wx_ff};
      dpos[1] = {1'b0, s_wy_ff} - {1'b0, s_xz_ff};
      dneg[1] = {1'b0, s_xz_ff} - {1'b0, s_wy_ff};
      dpos[2] = {1'b0, s_wz_ff} - {1'b0, s_xy_ff};
      dneg[2] = {1'b0, s_xy_ff} - {1'b0, s_wz_ff};
      for (int i = 0; i < 6; i++) begin
         offn[i] = -off_ff[i];
      end
   end

   // Magnitudes, signs and the norm.
   always_ff @(posedge clock) begin
      den_ff <= {1'b0, s_wx_ff} + {1'b0, s_yz_ff};
      zn_ff  <= (s_wx_ff == 64'd0) && (s_yz_ff == 64'd0);
      neg_ff[0] <= dpos[0][64];
      num_ff[0] <= dpos[0][64] ? dneg[0] : dpos[0];
      neg_ff[4] <= dpos[1][64];
      num_ff[4] <= dpos[1][64] ? dneg[1] : dpos[1];
      neg_ff[8] <= dpos[2][64];
      num_ff[8] <= dpos[2][64] ? dneg[2] : dpos[2];
      neg_ff[1] <= off_ff[0][64];
      num_ff[1] <= off_ff[0][64] ? {offn[0][63:0], 1'b0} : {off_ff[0][63:0], 1'b0};
      neg_ff[2] <= off_ff[1][64];
      num_ff[2] <= off_ff[1][64] ? {offn[1][63:0], 1'b0} : {off_ff[1][63:0], 1'b0};
      neg_ff[3] <= off_ff[2][64];
      num_ff[3] <= off_ff[2][64] ? {offn[2][63:0], 1'b0} : {off_ff[2][63:0], 1'b0};
      neg_ff[5] <= off_ff[3][64];
      num_ff[5] <= off_ff[3][64] ? {offn[3][63:0], 1'b0} : {off_ff[3][63:0], 1'b0};
      neg_ff[6] <= off_ff[4][64];
      num_ff[6] <= off_ff[4][64] ? {offn[4][63:0], 1'b0} : {off_ff[4][63:0], 1'b0};
      neg_ff[7] <= off_ff[5][64];
      num_ff[7] <= off_ff[5][64] ? {offn[5][63:0], 1'b0} : {off_ff[5][63:0], 1'b0};
   end

   // Divider lanes, one per matrix entry.
   for (genvar k = 0; k < 9; k++) begin : g_div
      qau_div_lane u_div (
         .clock (clock),
         .num   (num_ff[k]),
         .den   (den_ff),
         .neg   (neg_ff[k]),
         .quot  (quo[k])
      );
   end

   // Zero norm flag travels alongside the dividers.
   always_ff @(posedge clock) begin
      zd_ff[0] <= zn_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         zd_ff[i] <= zd_ff[i-1];
      end
   end

   // A zero norm yields the identity matrix.
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         if (zd_ff[DIV_LAT-1]) begin
            mat[k] = (k == 0 || k == 4 || k == 8) ? FIX_ONE : '0;
         end else begin
            mat[k] = quo[k];
         end
      end
   end

   assign zero_norm = zd_ff[DIV_LAT-1];

endmodule
